// File: rtl/triangle_circumcenter_3d_top_assert.svh
// Assertion macros for the triangle circumcenter block.
// Expects clk_i and rst_ni in the scope of the module that uses them.
`ifndef TRIANGLE_CIRCUMCENTER_3D_TOP_ASSERT_SVH
`define TRIANGLE_CIRCUMCENTER_3D_TOP_ASSERT_SVH

// same-cycle implication
`define TCC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TCC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/tcc_pkg.sv
// Shared constants for the triangle circumcenter block.
// No dependencies.
package tcc_pkg;

  localparam int TCC_COORD_WIDTH = 32;

endpackage

// File: rtl/tcc_if.sv
// Valid/ready stream interfaces for corner and center transactions.
// Depends on tcc_pkg.
interface tcc_in_if import tcc_pkg::*; #(
  parameter int W = TCC_COORD_WIDTH
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] p1_x;
  logic signed [W-1:0] p1_y;
  logic signed [W-1:0] p1_z;
  logic signed [W-1:0] p2_x;
  logic signed [W-1:0] p2_y;
  logic signed [W-1:0] p2_z;
  logic signed [W-1:0] p3_x;
  logic signed [W-1:0] p3_y;
  logic signed [W-1:0] p3_z;

  modport source (output valid, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z, p3_x, p3_y, p3_z,
                  input ready);
  modport sink   (input valid, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z, p3_x, p3_y, p3_z,
                  output ready);
endinterface

interface tcc_out_if import tcc_pkg::*; #(
  parameter int W = TCC_COORD_WIDTH
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] center_x;
  logic signed [W-1:0] center_y;
  logic signed [W-1:0] center_z;
  logic                degenerate;
  logic                clipped;

  modport source (output valid, center_x, center_y, center_z, degenerate, clipped,
                  input ready);
  modport sink   (input valid, center_x, center_y, center_z, degenerate, clipped,
                  output ready);
endinterface

// File: rtl/tcc_mul.sv
// Pipelined signed multiplier, one slice of the second operand per stage.
// No dependencies.
module tcc_mul #(
  parameter int WA     = 8,
  parameter int WB     = 8,
  parameter int STAGES = 2
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic signed [WA-1:0]  a_i,
  input  logic signed [WB-1:0]  b_i,
  output logic signed [WA+WB-1:0] p_o
);

  localparam int DG = (WB + STAGES - 1) / STAGES;
  localparam int BX = DG * STAGES;
  localparam int XW = WA + BX + 1;

  logic signed [WA-1:0] a_q   [STAGES-1];
  logic signed [BX-1:0] b_q   [STAGES-1];
  logic signed [XW-1:0] acc_q [STAGES];
  logic signed [BX-1:0] b_x;

  assign b_x = BX'(b_i);

  for (genvar k = 0; k < STAGES; k++) begin : g_stg
    logic signed [WA-1:0] a_in;
    logic signed [BX-1:0] b_in;
    logic signed [XW-1:0] acc_in;
    logic signed [XW-1:0] part;
    logic signed [WA+DG:0] prod;
    logic        [DG-1:0] dig;

    if (k == 0) begin : g_first
      assign a_in   = a_i;
      assign b_in   = b_x;
      assign acc_in = '0;
    end else begin : g_next
      assign a_in   = a_q[k-1];
      assign b_in   = b_q[k-1];
      assign acc_in = acc_q[k-1];
    end

    assign dig = b_in[k*DG +: DG];

    if (k == STAGES - 1) begin : g_top
      assign prod = a_in * $signed(dig);
    end else begin : g_low
      assign prod = a_in * $signed({1'b0, dig});
    end

    assign part = XW'(prod) <<< (k * DG);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        acc_q[k] <= acc_in + part;
      end
    end

    if (k < STAGES - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          a_q[k] <= a_in;
          b_q[k] <= b_in;
        end
      end
    end
  end

  assign p_o = acc_q[STAGES-1][WA+WB-1:0];

endmodule

// File: rtl/triangle_circumcenter_3d_top.sv
// Triangle circumcenter in 3D, barycentric weights, exact fixed-point intermediates, rounded result.
// Depends on tcc_pkg, tcc_if (tcc_in_if, tcc_out_if), tcc_mul and the assert header.
//
// Usage:
//   in_i carries one triangle per transaction (three corners, signed
//   fixed point); out_o carries its circumcenter, a degenerate flag for
//   collinear corners (center then zero) and a clipped flag when a
//   coordinate saturated. Both channels are valid/ready.
//   Throughput: one triangle per cycle while the receiver does not stall. LM
//   and LN are the stage counts of the two sliced multiplier banks, and the
//   divider resolves one quotient bit per stage for each of the three coordinates.
//   Reset clears all valid bits; the pipeline comes up empty and ready.
//   When the receiver stalls with a result waiting, every stage holds and
//   in_i.ready drops; nothing is lost or repeated. Bubbles are filled while
//   the output stage is empty.
`include "triangle_circumcenter_3d_top_assert.svh"

module triangle_circumcenter_3d_top import tcc_pkg::*; #(
  parameter int COORD_WIDTH = TCC_COORD_WIDTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tcc_in_if.sink     in_i,
  tcc_out_if.source  out_o
);

  localparam int W    = COORD_WIDTH;
  localparam int EW   = W + 1;
  localparam int PW   = 2 * EW;
  localparam int CW   = PW + 1;
  localparam int SW   = PW + 2;
  localparam int DW   = 2 * CW + 3;
  localparam int D2W  = DW + 1;
  localparam int WW   = 2 * SW;
  localparam int NPW  = WW + W;
  localparam int NW   = NPW + 2;
  localparam int NP2W = NW + 2;
  localparam int QB   = W + 1;
  localparam int RW   = D2W + 1;
  localparam int LM   = (SW + 15) / 16;
  localparam int LN   = (W + 7) / 8;
  localparam int T    = 9 + LM + LN + QB;

  localparam logic signed [W-1:0] CMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] CMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic        [QB-1:0] QLIM = {2'b01, {(W-1){1'b0}}};

  logic [T-1:0] valid_q;
  logic         adv;

  assign adv        = !valid_q[T-1] || out_o.ready;
  assign in_i.ready = adv;
  assign out_o.valid = valid_q[T-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (adv) begin
      valid_q <= {valid_q[T-2:0], in_i.valid};
    end
  end

  // stage 1: capture corners
  logic signed [W-1:0] p1_q [9];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      p1_q[0] <= in_i.p1_x;
      p1_q[1] <= in_i.p1_y;
      p1_q[2] <= in_i.p1_z;
      p1_q[3] <= in_i.p2_x;
      p1_q[4] <= in_i.p2_y;
      p1_q[5] <= in_i.p2_z;
      p1_q[6] <= in_i.p3_x;
      p1_q[7] <= in_i.p3_y;
      p1_q[8] <= in_i.p3_z;
    end
  end

  // stage 2: edges
  logic signed [W-1:0]  p2_q [9];
  logic signed [EW-1:0] e12_q [3];
  logic signed [EW-1:0] e13_q [3];
  logic signed [EW-1:0] e23_q [3];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      p2_q <= p1_q;
      for (int k = 0; k < 3; k++) begin
        e12_q[k] <= EW'(p1_q[k])   - EW'(p1_q[3+k]);
        e13_q[k] <= EW'(p1_q[k])   - EW'(p1_q[6+k]);
        e23_q[k] <= EW'(p1_q[3+k]) - EW'(p1_q[6+k]);
      end
    end
  end

  // stage 3: edge products
  logic signed [W-1:0]  p3_q [9];
  logic signed [PW-1:0] pc_q [6];
  logic signed [PW-1:0] m2323_q [3];
  logic signed [PW-1:0] m1213_q [3];
  logic signed [PW-1:0] m1313_q [3];
  logic signed [PW-1:0] m1223_q [3];
  logic signed [PW-1:0] m1212_q [3];
  logic signed [PW-1:0] m1323_q [3];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      p3_q    <= p2_q;
      pc_q[0] <= e12_q[1] * e23_q[2];
      pc_q[1] <= e12_q[2] * e23_q[1];
      pc_q[2] <= e12_q[2] * e23_q[0];
      pc_q[3] <= e12_q[0] * e23_q[2];
      pc_q[4] <= e12_q[0] * e23_q[1];
      pc_q[5] <= e12_q[1] * e23_q[0];
      for (int k = 0; k < 3; k++) begin
        m2323_q[k] <= e23_q[k] * e23_q[k];
        m1213_q[k] <= e12_q[k] * e13_q[k];
        m1313_q[k] <= e13_q[k] * e13_q[k];
        m1223_q[k] <= e12_q[k] * e23_q[k];
        m1212_q[k] <= e12_q[k] * e12_q[k];
        m1323_q[k] <= e13_q[k] * e23_q[k];
      end
    end
  end

  // stage 4: cross product and dot sums
  logic signed [W-1:0]  p4_q [9];
  logic signed [CW-1:0] cr_q [3];
  logic signed [SW-1:0] n23_q, d1213_q, n13_q, nd1223_q, n12_q, d1323_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      p4_q     <= p3_q;
      for (int k = 0; k < 3; k++) begin
        cr_q[k] <= CW'(pc_q[2*k]) - CW'(pc_q[2*k+1]);
      end
      n23_q    <= SW'(m2323_q[0]) + SW'(m2323_q[1]) + SW'(m2323_q[2]);
      d1213_q  <= SW'(m1213_q[0]) + SW'(m1213_q[1]) + SW'(m1213_q[2]);
      n13_q    <= SW'(m1313_q[0]) + SW'(m1313_q[1]) + SW'(m1313_q[2]);
      nd1223_q <= -(SW'(m1223_q[0]) + SW'(m1223_q[1]) + SW'(m1223_q[2]));
      n12_q    <= SW'(m1212_q[0]) + SW'(m1212_q[1]) + SW'(m1212_q[2]);
      d1323_q  <= SW'(m1323_q[0]) + SW'(m1323_q[1]) + SW'(m1323_q[2]);
    end
  end

  // first multiplier bank: squared cross terms and weights
  logic signed [2*CW-1:0] crsq [3];
  logic signed [WW-1:0]   wt   [3];

  for (genvar k = 0; k < 3; k++) begin : g_sq
    tcc_mul #(.WA(CW), .WB(CW), .STAGES(LM)) u_sq (
      .clk_i (clk_i),
      .en_i  (adv),
      .a_i   (cr_q[k]),
      .b_i   (cr_q[k]),
      .p_o   (crsq[k])
    );
  end

  tcc_mul #(.WA(SW), .WB(SW), .STAGES(LM)) u_wa (
    .clk_i (clk_i), .en_i (adv), .a_i (n23_q), .b_i (d1213_q), .p_o (wt[0])
  );
  tcc_mul #(.WA(SW), .WB(SW), .STAGES(LM)) u_wb (
    .clk_i (clk_i), .en_i (adv), .a_i (n13_q), .b_i (nd1223_q), .p_o (wt[1])
  );
  tcc_mul #(.WA(SW), .WB(SW), .STAGES(LM)) u_wc (
    .clk_i (clk_i), .en_i (adv), .a_i (n12_q), .b_i (d1323_q), .p_o (wt[2])
  );

  logic signed [W-1:0] pm_q [LM][9];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      pm_q[0] <= p4_q;
      for (int s = 1; s < LM; s++) begin
        pm_q[s] <= pm_q[s-1];
      end
    end
  end

  // stage 5: denominator, degenerate test
  logic signed [W-1:0]  p5_q [9];
  logic signed [WW-1:0] w5_q [3];
  logic        [DW-1:0] den5_q;
  logic                 deg5_q;
  logic        [DW-1:0] den5_d;

  assign den5_d = (DW'($unsigned(crsq[0])) + DW'($unsigned(crsq[1]))
                 + DW'($unsigned(crsq[2]))) << 1;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p5_q   <= pm_q[LM-1];
      w5_q   <= wt;
      den5_q <= den5_d;
      deg5_q <= (den5_d == '0);
    end
  end

  // second multiplier bank: weight times corner coordinate
  logic signed [NPW-1:0] wp [3][3];

  for (genvar j = 0; j < 3; j++) begin : g_wj
    for (genvar k = 0; k < 3; k++) begin : g_wk
      tcc_mul #(.WA(WW), .WB(W), .STAGES(LN)) u_wp (
        .clk_i (clk_i),
        .en_i  (adv),
        .a_i   (w5_q[j]),
        .b_i   (p5_q[3*j+k]),
        .p_o   (wp[j][k])
      );
    end
  end

  logic [DW-1:0] dn_q [LN];
  logic          dg_q [LN];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      dn_q[0] <= den5_q;
      dg_q[0] <= deg5_q;
      for (int s = 1; s < LN; s++) begin
        dn_q[s] <= dn_q[s-1];
        dg_q[s] <= dg_q[s-1];
      end
    end
  end

  // stage 6: numerators
  logic signed [NW-1:0] num6_q [3];
  logic        [DW-1:0] den6_q;
  logic                 deg6_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        num6_q[k] <= NW'(wp[0][k]) + NW'(wp[1][k]) + NW'(wp[2][k]);
      end
      den6_q <= dn_q[LN-1];
      deg6_q <= dg_q[LN-1];
    end
  end

  // stage 7: magnitude, rounding offset
  logic [NP2W-1:0] np7_q [3];
  logic            neg7_q [3];
  logic [DW-1:0]   den7_q;
  logic            deg7_q;
  logic [NW-1:0]   mag7 [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mag7[k] = num6_q[k][NW-1] ? NW'(-num6_q[k]) : NW'(num6_q[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        np7_q[k]  <= (NP2W'(mag7[k]) << 1) + NP2W'(den6_q);
        neg7_q[k] <= num6_q[k][NW-1];
      end
      den7_q <= den6_q;
      deg7_q <= deg6_q;
    end
  end

  // stage 8: overflow check, divider setup
  logic [RW-1:0]  rem8_q [3];
  logic [QB-1:0]  lo8_q  [3];
  logic           neg8_q [3];
  logic           ovf8_q [3];
  logic [D2W-1:0] d2_8_q;
  logic           deg8_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        ovf8_q[k] <= (np7_q[k] >> QB) >= NP2W'({den7_q, 1'b0});
        rem8_q[k] <= RW'(np7_q[k] >> QB);
        lo8_q[k]  <= np7_q[k][QB-1:0];
        neg8_q[k] <= neg7_q[k];
      end
      d2_8_q <= {den7_q, 1'b0};
      deg8_q <= deg7_q;
    end
  end

  // restoring divider, one quotient bit per stage
  logic [RW-1:0]  rem_q [QB-1][3];
  logic [QB-1:0]  lo_q  [QB-1][3];
  logic [D2W-1:0] d2_q  [QB-1];
  logic [QB-1:0]  qt_q  [QB][3];
  logic           neg_q [QB][3];
  logic           ovf_q [QB][3];
  logic           dgd_q [QB];

  for (genvar s = 0; s < QB; s++) begin : g_div
    logic [RW-1:0]  rem_in [3];
    logic [QB-1:0]  lo_in  [3];
    logic [QB-1:0]  qt_in  [3];
    logic           neg_in [3];
    logic           ovf_in [3];
    logic [D2W-1:0] d2_in;
    logic           dg_in;
    logic [RW-1:0]  rem_sh [3];
    logic [RW-1:0]  rem_nx [3];
    logic           ge     [3];

    if (s == 0) begin : g_first
      assign rem_in = rem8_q;
      assign lo_in  = lo8_q;
      assign neg_in = neg8_q;
      assign ovf_in = ovf8_q;
      assign d2_in  = d2_8_q;
      assign dg_in  = deg8_q;
      assign qt_in  = '{default: '0};
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign lo_in  = lo_q[s-1];
      assign neg_in = neg_q[s-1];
      assign ovf_in = ovf_q[s-1];
      assign d2_in  = d2_q[s-1];
      assign dg_in  = dgd_q[s-1];
      assign qt_in  = qt_q[s-1];
    end

    always_comb begin
      for (int k = 0; k < 3; k++) begin
        rem_sh[k] = {rem_in[k][RW-2:0], lo_in[k][QB-1-s]};
        ge[k]     = rem_sh[k] >= RW'(d2_in);
        rem_nx[k] = ge[k] ? rem_sh[k] - RW'(d2_in) : rem_sh[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        for (int k = 0; k < 3; k++) begin
          qt_q[s][k]  <= qt_in[k] | (QB'(ge[k]) << (QB-1-s));
          neg_q[s][k] <= neg_in[k];
          ovf_q[s][k] <= ovf_in[k];
        end
        dgd_q[s] <= dg_in;
      end
    end

    if (s < QB - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (adv) begin
          rem_q[s] <= rem_nx;
          lo_q[s]  <= lo_in;
          d2_q[s]  <= d2_in;
        end
      end
    end
  end

  // output stage: sign, saturate
  logic signed [W-1:0] res_d  [3];
  logic                clip_d [3];
  logic signed [W-1:0] res_q  [3];
  logic                clip_q;
  logic                deg_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (dgd_q[QB-1]) begin
        clip_d[k] = 1'b0;
        res_d[k]  = '0;
      end else if (neg_q[QB-1][k]) begin
        clip_d[k] = ovf_q[QB-1][k] || (qt_q[QB-1][k] > QLIM);
        res_d[k]  = clip_d[k] ? CMIN : -$signed(qt_q[QB-1][k][W-1:0]);
      end else begin
        clip_d[k] = ovf_q[QB-1][k] || (qt_q[QB-1][k] >= QLIM);
        res_d[k]  = clip_d[k] ? CMAX : $signed(qt_q[QB-1][k][W-1:0]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q  <= res_d;
      clip_q <= clip_d[0] || clip_d[1] || clip_d[2];
      deg_q  <= dgd_q[QB-1];
    end
  end

  assign out_o.center_x   = res_q[0];
  assign out_o.center_y   = res_q[1];
  assign out_o.center_z   = res_q[2];
  assign out_o.degenerate = deg_q;
  assign out_o.clipped    = clip_q;

  `TCC_ASSERT_IMP(a_deg_zero, out_o.valid && out_o.degenerate,
    out_o.center_x == '0 && out_o.center_y == '0 && out_o.center_z == '0 && !out_o.clipped,
    "degenerate result with nonzero center")
  `TCC_ASSERT_IMP(a_clip_limit, out_o.valid && out_o.clipped,
    out_o.center_x == CMAX || out_o.center_x == CMIN || out_o.center_y == CMAX ||
    out_o.center_y == CMIN || out_o.center_z == CMAX || out_o.center_z == CMIN,
    "clipped result without a saturated coordinate")
  `TCC_ASSERT_IMP(a_rise_adv, $rose(valid_q[T-1]), $past(adv),
    "output valid rose while the pipeline was stalled")

endmodule
